// ===== rtl/core/pearson_correlation_assert.svh =====
// Assertion macros for the Pearson correlation block.
// Included by the top level; the assertions compile away under SYNTHESIS.
`ifndef PEARSON_CORRELATION_ASSERT_SVH
`define PEARSON_CORRELATION_ASSERT_SVH

`ifndef SYNTHESIS

`define PCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define PCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCC_ASSERT(lbl, prop, msg)

`define PCC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/pcc_pkg.sv =====
// Shared types and constants for the Pearson correlation block.
// Used by pcc_mul and pearson_correlation; depends on nothing.
`default_nettype none

package pcc_pkg;

  localparam int OP_W   = 64;   // multiplier operand width, signed
  localparam int PROD_W = 128;  // multiplier product width, signed
  localparam int DIG_W  = 4;    // multiplier bits retired per cycle
  localparam int SRCH_W = 148;  // width of the root search terms
  localparam int Q_W    = 16;   // result width
  localparam int FRAC_SHIFT = 30;  // Q1.15 squared

  typedef struct packed {
    logic                    start;
    logic signed [OP_W-1:0]  x;
    logic signed [OP_W-1:0]  y;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/pearson_correlation.sv =====
// Pearson correlation of paired samples, result in signed Q1.15.
// Depends on pcc_pkg, pcc_mul and pearson_correlation_assert.svh.
//
//   channel  signals                                  direction
//   sample   sample_valid/stall, a, b, last_pair      in
//   result   result_valid/stall, correlation, flag    out
//
// A pair takes a capture step plus three passes through the shared multiplier
// (a*b, a*a and b*b), each running until the bits of |y| are used up.
// The last pair adds six sum products, the variance product and the squared
// numerator on the same multiplier and a bit-serial root search; the last two
// products and the search are skipped when a variance is not positive.
// Reset clears the count, sums and overflow flag; sample_stall is high while busy.
// A finished result waits in the output register while new pairs are taken.
`default_nettype none

module pearson_correlation #(
  parameter int MAX_PAIRS   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_stall,
  input  wire logic signed [15:0] sample_a,
  input  wire logic signed [15:0] sample_b,
  input  wire logic              last_pair,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic signed [15:0]     correlation,
  output logic                   count_overflow
);
  import pcc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int PSUM_W = 2 * SAMPLE_BITS + CNT_W;
  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_MAB, S_MAA, S_MBB, S_NAB, S_AB, S_NAA, S_AA,
    S_NBB, S_BB, S_CHK, S_DEN, S_MM, S_SA, S_SB, S_OUT
  } state_t;

  state_t                    state;
  logic                      issued;
  logic                      last_q;
  logic signed [SAMPLE_BITS-1:0] a_q;
  logic signed [SAMPLE_BITS-1:0] b_q;
  logic [CNT_W-1:0]          pair_count;
  logic signed [SUM_W-1:0]   total_a;
  logic signed [SUM_W-1:0]   total_b;
  logic signed [PSUM_W-1:0]  total_ab;
  logic signed [PSUM_W-1:0]  total_aa;
  logic signed [PSUM_W-1:0]  total_bb;
  logic                      overflow_seen;
  logic signed [OP_W-1:0]    tmp;
  logic signed [OP_W-1:0]    num;
  logic signed [OP_W-1:0]    var_a;
  logic signed [OP_W-1:0]    var_b;
  logic [SRCH_W-1:0]         den;
  logic [SRCH_W-1:0]         rhs;
  logic [SRCH_W-1:0]         part;
  logic [SRCH_W-1:0]         qden;
  logic [SRCH_W-1:0]         trial;
  logic [SRCH_W-1:0]         trial_full;
  logic [3:0]                bit_k;
  logic [Q_W-1:0]            q;
  logic signed [OP_W-1:0]    num_mag;
  logic signed [OP_W-1:0]    a_ext;
  logic signed [OP_W-1:0]    b_ext;
  logic signed [OP_W-1:0]    n_ext;
  logic signed [OP_W-1:0]    diff;
  logic signed [SAMPLE_BITS-1:0] in_a;
  logic signed [SAMPLE_BITS-1:0] in_b;
  mul_req_t                  mreq;
  mul_rsp_t                  mrsp;

  pcc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign sample_stall = (state != S_IDLE);
  assign in_a    = sample_a[SAMPLE_BITS-1:0];
  assign in_b    = sample_b[SAMPLE_BITS-1:0];
  assign a_ext   = OP_W'(a_q);
  assign b_ext   = OP_W'(b_q);
  assign n_ext   = OP_W'(pair_count);
  assign num_mag = num[OP_W-1] ? (OP_W'(0) - num) : num;
  assign diff    = tmp - OP_W'(mrsp.product);
  assign trial_full = trial + (den << {bit_k, 1'b0});

  always_comb begin
    mreq.start = (state inside {S_MAB, S_MAA, S_MBB, S_NAB, S_AB, S_NAA,
                                S_AA, S_NBB, S_BB, S_DEN, S_MM}) && !issued;
    mreq.x = a_ext;
    mreq.y = b_ext;
    case (state)
      S_MAA: begin mreq.x = a_ext; mreq.y = a_ext; end
      S_MBB: begin mreq.x = b_ext; mreq.y = b_ext; end
      S_NAB: begin mreq.x = n_ext; mreq.y = OP_W'(total_ab); end
      S_AB:  begin mreq.x = OP_W'(total_a); mreq.y = OP_W'(total_b); end
      S_NAA: begin mreq.x = n_ext; mreq.y = OP_W'(total_aa); end
      S_AA:  begin mreq.x = OP_W'(total_a); mreq.y = OP_W'(total_a); end
      S_NBB: begin mreq.x = n_ext; mreq.y = OP_W'(total_bb); end
      S_BB:  begin mreq.x = OP_W'(total_b); mreq.y = OP_W'(total_b); end
      S_DEN: begin mreq.x = var_a; mreq.y = var_b; end
      S_MM:  begin mreq.x = num_mag; mreq.y = num_mag; end
      default: begin mreq.x = a_ext; mreq.y = b_ext; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      issued        <= 1'b0;
      pair_count    <= '0;
      total_a       <= '0;
      total_b       <= '0;
      total_ab      <= '0;
      total_aa      <= '0;
      total_bb      <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      if (mrsp.done) begin
        issued <= 1'b0;
      end else if (mreq.start) begin
        issued <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            a_q    <= in_a;
            b_q    <= in_b;
            last_q <= last_pair;
            if (pair_count < CNT_W'(MAX_PAIRS)) begin
              pair_count <= pair_count + CNT_W'(1);
              total_a    <= total_a + SUM_W'(in_a);
              total_b    <= total_b + SUM_W'(in_b);
              state      <= S_MAB;
            end else begin
              overflow_seen <= 1'b1;
              state <= last_pair ? S_NAB : S_IDLE;
            end
          end
        end
        S_MAB: if (mrsp.done) begin
          total_ab <= total_ab + PSUM_W'(mrsp.product);
          state    <= S_MAA;
        end
        S_MAA: if (mrsp.done) begin
          total_aa <= total_aa + PSUM_W'(mrsp.product);
          state    <= S_MBB;
        end
        S_MBB: if (mrsp.done) begin
          total_bb <= total_bb + PSUM_W'(mrsp.product);
          state    <= last_q ? S_NAB : S_IDLE;
        end
        S_NAB: if (mrsp.done) begin
          tmp   <= OP_W'(mrsp.product);
          state <= S_AB;
        end
        S_AB: if (mrsp.done) begin
          num   <= diff;
          state <= S_NAA;
        end
        S_NAA: if (mrsp.done) begin
          tmp   <= OP_W'(mrsp.product);
          state <= S_AA;
        end
        S_AA: if (mrsp.done) begin
          var_a <= diff;
          state <= S_NBB;
        end
        S_NBB: if (mrsp.done) begin
          tmp   <= OP_W'(mrsp.product);
          state <= S_BB;
        end
        S_BB: if (mrsp.done) begin
          var_b <= diff;
          state <= S_CHK;
        end
        S_CHK: begin
          q <= '0;
          // Fewer than two pairs or a constant sample gives a zero variance.
          if (var_a <= 0 || var_b <= 0) begin
            state <= S_OUT;
          end else begin
            state <= S_DEN;
          end
        end
        S_DEN: if (mrsp.done) begin
          den   <= SRCH_W'(mrsp.product);
          state <= S_MM;
        end
        S_MM: if (mrsp.done) begin
          rhs   <= SRCH_W'(mrsp.product) << FRAC_SHIFT;
          part  <= '0;
          qden  <= '0;
          bit_k <= 4'(Q_W - 1);
          state <= S_SA;
        end
        // Greedy square-root search: keep q*q*den and q*den, try one bit of q.
        S_SA: begin
          trial <= part + (qden << ({1'b0, bit_k} + 5'd1));
          state <= S_SB;
        end
        S_SB: begin
          if (trial_full <= rhs) begin
            part     <= trial_full;
            qden     <= qden + (den << bit_k);
            q[bit_k] <= 1'b1;
          end
          if (bit_k == '0) begin
            state <= S_OUT;
          end else begin
            bit_k <= bit_k - 4'd1;
            state <= S_SA;
          end
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid   <= 1'b1;
            count_overflow <= overflow_seen;
            if (num[OP_W-1]) begin
              correlation <= Q_W'(0) - q;
            end else begin
              correlation <= (q > Q_MAX) ? Q_MAX : q;
            end
            pair_count    <= '0;
            total_a       <= '0;
            total_b       <= '0;
            total_ab      <= '0;
            total_aa      <= '0;
            total_bb      <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "pearson_correlation_assert.svh"

  `PCC_ASSERT(a_count_bound, pair_count <= CNT_W'(MAX_PAIRS), "pair count above maximum")
  `PCC_ASSERT(a_result_source, $rose(result_valid) |-> $past(state == S_OUT), "result without final step")
  `PCC_ASSERT(a_search_bound, (state == S_SA) |-> (part <= rhs), "search partial exceeds bound")
  `PCC_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !result_valid), "reset not idle")

endmodule

`default_nettype wire

// ===== rtl/core/pcc_mul.sv =====
// Shared sequential signed multiplier, four multiplier bits per cycle.
// Depends on pcc_pkg for the request and response structs.
`default_nettype none

module pcc_mul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pcc_pkg::mul_req_t req,
  output pcc_pkg::mul_rsp_t      rsp
);
  import pcc_pkg::*;

  logic                  busy;
  logic                  neg;
  logic [PROD_W-1:0]     mcand;
  logic [OP_W-1:0]       mplier;
  logic [PROD_W-1:0]     acc;
  logic [OP_W-1:0]       mag_x;
  logic [OP_W-1:0]       mag_y;

  assign mag_x = req.x[OP_W-1] ? (OP_W'(0) - req.x) : req.x;
  assign mag_y = req.y[OP_W-1] ? (OP_W'(0) - req.y) : req.y;

  // Magnitudes are multiplied; the sign is applied once when the multiplier runs out.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else if (!busy) begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        neg    <= req.x[OP_W-1] ^ req.y[OP_W-1];
        mcand  <= PROD_W'(mag_x);
        mplier <= mag_y;
        acc    <= '0;
      end
    end else if (mplier == '0) begin
      busy        <= 1'b0;
      rsp.done    <= 1'b1;
      rsp.product <= neg ? (PROD_W'(0) - acc) : acc;
    end else begin
      rsp.done <= 1'b0;
      acc      <= acc + mcand * PROD_W'(mplier[DIG_W-1:0]);
      mcand    <= mcand << DIG_W;
      mplier   <= mplier >> DIG_W;
    end
  end

endmodule

`default_nettype wire
